// File: hw/rtl/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and constants for the MIDI voice allocator.
// ----------------------------------------------------------------------------
package mva_pkg;

    localparam int VOICE_COUNT_DEF = 8;

    localparam logic [7:0] MSG_NOTE_ON  = 8'h90;
    localparam logic [7:0] MSG_NOTE_OFF = 8'h80;
    localparam logic [7:0] MSG_CTRL     = 8'hB0;
    localparam logic [7:0] CTRL_ATTACK  = 8'h4A;

    localparam logic [3:0] KIND_NOTE_ON  = MSG_NOTE_ON[7:4];
    localparam logic [3:0] KIND_NOTE_OFF = MSG_NOTE_OFF[7:4];
    localparam logic [3:0] KIND_CTRL     = MSG_CTRL[7:4];

    localparam int SCAN_LANES = 8;
    localparam int LW         = $clog2(SCAN_LANES);

    localparam int CMDQ_DEPTH = 2;
    localparam int CQ_PW      = $clog2(CMDQ_DEPTH);
    localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);

    localparam logic [1:0] LAST_IDX_NOTE_ON = 2'd3;
    localparam logic [1:0] LAST_IDX_SHORT   = 2'd1;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] data_first;
        logic [7:0] data_second;
    } in_item_t;

    typedef struct packed {
        logic [7:0] link_byte;
        logic       last_byte;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_NOTE_ON,
        CMD_NOTE_OFF,
        CMD_CTRL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] note;
        logic [6:0] velocity;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SCAN,
        ST_EMIT
    } back_state_t;

endpackage

// File: hw/rtl/mva_front.sv
// ----------------------------------------------------------------------------
// mva_front
// Message decoder: checks a MIDI message and turns it into a command.
// ----------------------------------------------------------------------------
module mva_front
    import mva_pkg::*;
(
    input  in_item_t msg,
    input  logic     push,
    input  logic     q_full,
    output logic     full,
    output cmd_t     cmd,
    output logic     cmd_wr
);

    logic [3:0] kind;
    logic       data_ok;
    logic       keep;

    assign kind    = msg.status_byte[7:4];
    assign data_ok = !msg.data_first[7] && !msg.data_second[7];
    assign full    = q_full;

    always_comb
    begin
        keep         = 1'b0;
        cmd.kind     = CMD_CTRL;
        cmd.note     = msg.data_first[6:0];
        cmd.velocity = msg.data_second[6:0];
        if (data_ok)
        begin
            if (kind == KIND_NOTE_ON && msg.data_second != 8'd0)
            begin
                keep     = 1'b1;
                cmd.kind = CMD_NOTE_ON;
            end
            else if (kind inside {KIND_NOTE_ON, KIND_NOTE_OFF})
            begin
                keep     = 1'b1;
                cmd.kind = CMD_NOTE_OFF;
            end
            else if (kind == KIND_CTRL && msg.data_first == CTRL_ATTACK)
            begin
                keep     = 1'b1;
                cmd.kind = CMD_CTRL;
            end
        end
    end

    assign cmd_wr = push && !q_full && keep;

endmodule

// File: hw/rtl/mva_cmdq.sv
// ----------------------------------------------------------------------------
// mva_cmdq
// Short command queue between decoder and voice sequencer.
// ----------------------------------------------------------------------------
module mva_cmdq
    import mva_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t wr_data,
    input  logic wr_en,
    output logic full,
    output cmd_t rd_data,
    output logic rd_vld,
    input  logic rd_en
);

    cmd_t             mem [CMDQ_DEPTH];
    logic [CQ_PW-1:0] head_reg;
    logic [CQ_PW-1:0] tail_reg;
    logic [CQ_CW-1:0] cnt_reg;
    logic [CQ_CW-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == CQ_CW'(CMDQ_DEPTH));
    assign rd_vld  = (cnt_reg != '0);
    assign rd_data = mem[head_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && rd_vld;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[tail_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (do_rd)
            begin
                head_reg <= head_reg + 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/mva_back.sv
// ----------------------------------------------------------------------------
// mva_back
// Voice sequencer: slot table, round-robin pointer, note search, byte output.
// ----------------------------------------------------------------------------
module mva_back
    import mva_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_vld,
    output logic      cmd_pop,
    output out_item_t link,
    output logic      empty,
    input  logic      pop
);

    localparam int VW      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int NGROUPS = (VOICE_COUNT + SCAN_LANES - 1) / SCAN_LANES;
    localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int MW      = NGROUPS * SCAN_LANES;

    back_state_t            state_reg;
    back_state_t            state_next;
    cmd_t                   cmd_reg;
    logic [VW-1:0]          voice_reg;
    logic [VW-1:0]          next_voice_reg;
    logic [VW-1:0]          next_voice_next;
    logic [GW-1:0]          group_reg;
    logic [MW-1:0]          match_reg;
    logic [MW-1:0]          match_vec;
    logic [1:0]             byte_idx_reg;
    logic [6:0]             slot_note_reg [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] slot_active_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic [SCAN_LANES-1:0]  group_bits;
    logic                   hit_any;
    logic [LW-1:0]          hit_lane;
    logic [VW-1:0]          hit_idx;
    logic                   last_group;
    logic                   out_ld;
    logic                   emit_last;
    logic [7:0]             emit_byte;
    logic                   note_wr;
    logic                   slot_clr;

    genvar gi;
    for (gi = 0; gi < MW; gi++)
    begin : g_match
        if (gi < VOICE_COUNT)
        begin : g_slot
            assign match_vec[gi] = slot_active_reg[gi] &&
                                   (slot_note_reg[gi] == cmd_reg.note);
        end
        else
        begin : g_pad
            assign match_vec[gi] = 1'b0;
        end
    end

    assign group_bits = match_reg[group_reg * SCAN_LANES +: SCAN_LANES];
    assign hit_any    = |group_bits;
    assign last_group = (group_reg == GW'(NGROUPS - 1));
    assign hit_idx    = VW'({group_reg, hit_lane});

    always_comb
    begin
        hit_lane = '0;
        for (int k = SCAN_LANES - 1; k >= 0; k--)
        begin
            if (group_bits[k])
            begin
                hit_lane = LW'(k);
            end
        end
    end

    assign next_voice_next = (next_voice_reg == VW'(VOICE_COUNT - 1)) ? '0
                                                                     : next_voice_reg + 1'b1;

    // emitted byte for the current run position
    always_comb
    begin
        emit_byte = MSG_CTRL;
        emit_last = (byte_idx_reg == LAST_IDX_SHORT);
        case (cmd_reg.kind)
            CMD_NOTE_ON:
            begin
                emit_last = (byte_idx_reg == LAST_IDX_NOTE_ON);
                case (byte_idx_reg)
                    2'd0:    emit_byte = MSG_NOTE_ON;
                    2'd1:    emit_byte = 8'(voice_reg);
                    2'd2:    emit_byte = {1'b0, cmd_reg.note};
                    default: emit_byte = {1'b0, cmd_reg.velocity};
                endcase
            end
            CMD_NOTE_OFF:
            begin
                emit_byte = (byte_idx_reg == 2'd0) ? MSG_NOTE_OFF : 8'(voice_reg);
            end
            default:
            begin
                emit_byte = (byte_idx_reg == 2'd0) ? MSG_CTRL : CTRL_ATTACK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_vld)
                begin
                    state_next = (cmd.kind == CMD_NOTE_OFF) ? ST_MATCH : ST_EMIT;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit_any || last_group)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ld && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop  = (state_reg == ST_IDLE) && cmd_vld;
        note_wr  = cmd_pop && (cmd.kind == CMD_NOTE_ON);
        slot_clr = (state_reg == ST_SCAN) && hit_any;
        out_ld   = (state_reg == ST_EMIT) && (!out_valid_reg || pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            next_voice_reg  <= '0;
            slot_active_reg <= '0;
            out_valid_reg   <= 1'b0;
            byte_idx_reg    <= '0;
            group_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop && cmd.kind != CMD_CTRL)
            begin
                next_voice_reg <= next_voice_next;
            end
            if (note_wr)
            begin
                slot_active_reg[next_voice_reg] <= 1'b1;
            end
            if (slot_clr)
            begin
                slot_active_reg[hit_idx] <= 1'b0;
            end
            if (out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd_pop)
            begin
                byte_idx_reg <= '0;
            end
            else if (out_ld)
            begin
                byte_idx_reg <= byte_idx_reg + 1'b1;
            end
            if (state_reg == ST_MATCH)
            begin
                group_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                group_reg <= group_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg   <= cmd;
            voice_reg <= next_voice_reg;
        end
        if (note_wr)
        begin
            slot_note_reg[next_voice_reg] <= cmd.note;
        end
        if (state_reg == ST_MATCH)
        begin
            match_reg <= match_vec;
        end
        if (state_reg == ST_SCAN && state_next == ST_EMIT)
        begin
            voice_reg <= hit_any ? hit_idx : '0;
        end
        if (out_ld)
        begin
            out_reg.link_byte <= emit_byte;
            out_reg.last_byte <= emit_last;
        end
    end

    assign link  = out_reg;
    assign empty = !out_valid_reg;

    a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_voice_reg <= VW'(VOICE_COUNT - 1))
        else $error("voice pointer out of range");

    a_note_on_marks: assert property (@(posedge clk) disable iff (!rst_n)
        note_wr |=> slot_active_reg[$past(next_voice_reg)])
        else $error("note-on did not mark its slot active");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ld && emit_last) |=> (state_reg == ST_IDLE))
        else $error("run did not end after its final byte");

    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        slot_clr |=> !slot_active_reg[$past(hit_idx)])
        else $error("note-off hit left its slot active");

endmodule

// File: hw/rtl/midi_voice_allocator.sv
// ----------------------------------------------------------------------------
// midi_voice_allocator
// Round-robin MIDI voice allocator with a serial link-byte output queue.
// ----------------------------------------------------------------------------
// Sequence: note-on and control change go from idle straight to byte output;
//   note-off first passes the match and scan states, eight slots per scan step.
// Output: the sequencer emits one link byte a cycle while the receiver pops, and
//   takes the next command only once the last byte of a run is loaded.
// Reset: all voices inactive, pointer at voice 0, queues empty.
// ----------------------------------------------------------------------------
module midi_voice_allocator
    import mva_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  msg,
    input  logic      push,
    output logic      full,
    output out_item_t link,
    output logic      empty,
    input  logic      pop
);

    cmd_t front_cmd;
    logic front_wr;
    logic q_full;
    cmd_t q_cmd;
    logic q_vld;
    logic q_pop;

    mva_front u_front (
        .msg    (msg),
        .push   (push),
        .q_full (q_full),
        .full   (full),
        .cmd    (front_cmd),
        .cmd_wr (front_wr)
    );

    mva_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (front_cmd),
        .wr_en   (front_wr),
        .full    (q_full),
        .rd_data (q_cmd),
        .rd_vld  (q_vld),
        .rd_en   (q_pop)
    );

    mva_back #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (q_cmd),
        .cmd_vld (q_vld),
        .cmd_pop (q_pop),
        .link    (link),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

// File: test/midi_voice_allocator_test.sv
// ----------------------------------------------------------------------------
// midi_voice_allocator_test
// Drives three-byte MIDI messages into the voice allocator and checks every
// link beat against the directed table or a local voice-slot tracker. A directed table covers the
// boundary and rejection cases, then biased random traffic with random gaps,
// a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module midi_voice_allocator_test;
    import mva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DIR_ROWS     = 24;
    localparam int unsigned RANDOM_ITEMS = 386;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned BURST_ITEMS  = 12;
    localparam bit          TYPED        = 1'b1;
    localparam bit          PREDICTED    = 1'b0;

    // status types the block must drop
    localparam logic [7:0] MSG_POLY_AT = 8'hA0;
    localparam logic [7:0] MSG_PROG    = 8'hC0;
    localparam logic [7:0] MSG_SYSTEM  = 8'hF0;

    typedef struct packed {
        in_item_t    item;
        logic        typed;
        logic [2:0]  beats;
        logic [31:0] run;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    in_item_t  msg;
    logic      push;
    logic      full;
    out_item_t link;
    logic      empty;
    logic      pop;

    logic [6:0] voice_note [VOICE_COUNT_DEF];
    logic       voice_on   [VOICE_COUNT_DEF];
    int         voice_ptr;

    out_item_t   link_expect [$];
    dir_row_t    dir_rows [DIR_ROWS];
    int unsigned faults;
    bit          calm;
    bit          hold_link;

    midi_voice_allocator u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .push  (push),
        .full  (full),
        .link  (link),
        .empty (empty),
        .pop   (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void queue_run(input logic [31:0] run, input int n);
        out_item_t beat;
        for (int k = 0; k < n; k++)
        begin
            beat.link_byte = run[31 - 8 * k -: 8];
            beat.last_byte = (k == n - 1);
            link_expect.push_back(beat);
        end
    endfunction

    // updates the slot tracker and queues the expected run when keep is set; returns the number of link beats produced
    function automatic int allot_voice(input in_item_t m, input bit keep);
        logic [3:0]  kind;
        logic [31:0] run;
        int          n;
        int          hit;
        bit          found;
        kind  = m.status_byte[7:4];
        n     = 0;
        hit   = 0;
        found = 1'b0;
        if (kind != KIND_NOTE_ON && kind != KIND_NOTE_OFF && kind != KIND_CTRL)
            return 0;
        if (m.data_first[7] || m.data_second[7])
            return 0;
        if (kind == KIND_NOTE_ON && m.data_second != 8'd0)
        begin
            voice_note[voice_ptr] = m.data_first[6:0];
            voice_on[voice_ptr]   = 1'b1;
            run = {MSG_NOTE_ON, 8'(voice_ptr), m.data_first, m.data_second};
            n   = 4;
            voice_ptr = (voice_ptr + 1) % VOICE_COUNT_DEF;
        end
        else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF)
        begin
            for (int i = 0; i < VOICE_COUNT_DEF; i++)
            begin
                if (!found && voice_on[i] && voice_note[i] == m.data_first[6:0])
                begin
                    voice_on[i] = 1'b0;
                    hit   = i;
                    found = 1'b1;
                end
            end
            run = {MSG_NOTE_OFF, 8'(hit), 16'd0};
            n   = 2;
            voice_ptr = (voice_ptr + 1) % VOICE_COUNT_DEF;
        end
        else if (m.data_first == CTRL_ATTACK)
        begin
            run = {MSG_CTRL, CTRL_ATTACK, 16'd0};
            n   = 2;
        end
        if (keep && n != 0)
            queue_run(run, n);
        return n;
    endfunction

    function automatic in_item_t draw_message();
        in_item_t    m;
        int unsigned pick;
        logic [7:0]  chan;
        pick = $urandom_range(0, 99);
        chan = 8'($urandom_range(0, 15));
        m.data_first  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
                                                     : 8'(60 + $urandom_range(0, 7));
        m.data_second = 8'($urandom_range(0, 127));
        if (pick < 40)
        begin
            m.status_byte = MSG_NOTE_ON | chan;
            m.data_second = 8'($urandom_range(1, 127));
        end
        else if (pick < 55)
            m.status_byte = MSG_NOTE_OFF | chan;
        else if (pick < 65)
        begin
            m.status_byte = MSG_NOTE_ON | chan;
            m.data_second = 8'd0;
        end
        else if (pick < 75)
        begin
            m.status_byte = MSG_CTRL | chan;
            if ($urandom_range(0, 1) == 0)
                m.data_first = CTRL_ATTACK;
        end
        else
            m = in_item_t'(24'($urandom));
        return m;
    endfunction

    // prediction is taken at the accepting edge
    task automatic offer_message(input in_item_t m, input bit keep, output int n);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        msg  <= m;
        do @(posedge clk); while (full);
        n = allot_voice(m, keep);
    endtask

    initial
    begin
        out_item_t   want;
        int unsigned pause;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_link)
            begin
                hold_link = 1'b0;
                pause = HOLD_CYCLES;
            end
            else
                pause = calm ? 0 : $urandom_range(0, 9);
            if (pause != 0)
            begin
                pop <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            if (link_expect.size() == 0)
            begin
                $error("unexpected link beat %h last %b", link.link_byte, link.last_byte);
                faults++;
            end
            else
            begin
                want = link_expect.pop_front();
                if (link.link_byte !== want.link_byte)
                begin
                    $error("link_byte expected %h got %h", want.link_byte, link.link_byte);
                    faults++;
                end
                if (link.last_byte !== want.last_byte)
                begin
                    $error("last_byte expected %b got %b", want.last_byte, link.last_byte);
                    faults++;
                end
            end
        end
    end

    initial
    begin
        in_item_t    m;
        int          n;
        int unsigned counted;
        int unsigned issued;
        bit          burst_done;
        bit          drain_done;

        faults     = 0;
        calm       = 1'b0;
        hold_link  = 1'b0;
        counted    = 0;
        issued     = 0;
        burst_done = 1'b0;
        drain_done = 1'b0;
        voice_ptr  = 0;
        for (int i = 0; i < VOICE_COUNT_DEF; i++)
        begin
            voice_note[i] = 7'd0;
            voice_on[i]   = 1'b0;
        end

        dir_rows[0]  = {MSG_NOTE_ON, 8'd60, 8'd100, TYPED, 3'd4,
                        MSG_NOTE_ON, 8'd0, 8'd60, 8'd100};
        dir_rows[1]  = {MSG_NOTE_OFF | 8'h0F, 8'd60, 8'd0, TYPED, 3'd2,
                        MSG_NOTE_OFF, 8'd0, 16'd0};
        // note held by no voice
        dir_rows[2]  = {MSG_NOTE_OFF, 8'h7F, 8'h7F, TYPED, 3'd2, MSG_NOTE_OFF, 8'd0, 16'd0};
        // note-on with zero velocity acts as note-off
        dir_rows[3]  = {MSG_NOTE_ON | 8'h05, 8'd0, 8'd0, TYPED, 3'd2,
                        MSG_NOTE_OFF, 8'd0, 16'd0};
        dir_rows[4]  = {MSG_CTRL | 8'h03, CTRL_ATTACK, 8'h7F, TYPED, 3'd2,
                        MSG_CTRL, CTRL_ATTACK, 16'd0};
        dir_rows[5]  = {MSG_CTRL, CTRL_ATTACK + 8'd1, 8'd0, TYPED, 3'd0, 32'd0};
        dir_rows[6]  = {MSG_CTRL | 8'h0F, 8'd0, 8'h7F, TYPED, 3'd0, 32'd0};
        dir_rows[7]  = {MSG_POLY_AT, 8'd60, 8'd100, TYPED, 3'd0, 32'd0};
        dir_rows[8]  = {MSG_SYSTEM | 8'h0F, 8'hFF, 8'hFF, TYPED, 3'd0, 32'd0};
        dir_rows[9]  = {MSG_PROG | 8'h0A, CTRL_ATTACK, 8'h40, TYPED, 3'd0, 32'd0};
        dir_rows[10] = {MSG_NOTE_ON, 8'h80, 8'h40, TYPED, 3'd0, 32'd0};
        dir_rows[11] = {MSG_NOTE_ON | 8'h01, 8'h40, 8'hFF, TYPED, 3'd0, 32'd0};
        dir_rows[12] = {MSG_CTRL, CTRL_ATTACK | 8'h80, 8'd0, TYPED, 3'd0, 32'd0};
        dir_rows[13] = {MSG_NOTE_OFF, 8'h80, 8'd0, TYPED, 3'd0, 32'd0};
        dir_rows[14] = {MSG_NOTE_ON | 8'h0F, 8'h7F, 8'h7F, PREDICTED, 3'd0, 32'd0};
        dir_rows[15] = {MSG_NOTE_ON, 8'd0, 8'd1, PREDICTED, 3'd0, 32'd0};
        // same note on two voices, then freed from the lower one
        dir_rows[16] = {MSG_NOTE_ON, 8'd64, 8'd1, PREDICTED, 3'd0, 32'd0};
        dir_rows[17] = {MSG_NOTE_ON, 8'd64, 8'h7F, PREDICTED, 3'd0, 32'd0};
        dir_rows[18] = {MSG_NOTE_OFF, 8'd64, 8'd0, PREDICTED, 3'd0, 32'd0};
        // pointer wraps round and reaches a voice still sounding
        for (int r = 19; r < DIR_ROWS; r++)
            dir_rows[r] = {MSG_NOTE_ON | 8'(r % 16), 8'(r - 9), 8'd64, PREDICTED, 3'd0, 32'd0};

        rst_n <= 1'b0;
        push  <= 1'b0;
        msg   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            offer_message(dir_rows[r].item, !dir_rows[r].typed, n);
            if (dir_rows[r].typed)
                queue_run(dir_rows[r].run, dir_rows[r].beats);
        end

        // sender waits for a full drain
        push <= 1'b0;
        wait (link_expect.size() == 0);
        @(posedge clk);

        while (counted < RANDOM_ITEMS)
        begin
            if (issued % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (!burst_done && counted >= 150)
            begin
                burst_done = 1'b1;
                hold_link  = 1'b1;
                calm       = 1'b1;
                for (int b = 0; b < BURST_ITEMS; b++)
                begin
                    m.status_byte = MSG_NOTE_ON | 8'($urandom_range(0, 15));
                    m.data_first  = 8'($urandom_range(0, 127));
                    m.data_second = 8'($urandom_range(1, 127));
                    offer_message(m, 1'b1, n);
                    counted++;
                end
                calm = 1'b0;
            end
            if (!drain_done && counted >= 300)
            begin
                drain_done = 1'b1;
                push <= 1'b0;
                wait (link_expect.size() == 0);
                @(posedge clk);
            end
            m = draw_message();
            offer_message(m, 1'b1, n);
            issued++;
            counted++;
        end

        push <= 1'b0;
        wait (link_expect.size() == 0);
        repeat (16) @(posedge clk);
        if (faults == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mva_pkg.sv
hw/rtl/mva_front.sv
hw/rtl/mva_cmdq.sv
hw/rtl/mva_back.sv
hw/rtl/midi_voice_allocator.sv
test/midi_voice_allocator_test.sv
